/* rtl/iae_pkg.sv */
`timescale 1ns / 1ps

package iae_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int NUMBER_BITS = 31;
	localparam int CHAR_W      = 8;
	localparam int VALUE_W     = 64;
	localparam int TERM_BITS   = VALUE_W - 1;
	localparam int CNT_W       = $clog2(TERM_BITS);

	localparam logic [VALUE_W-1:0] SMAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] SMIN = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		CLS_DIGIT = 3'd0,
		CLS_SPACE = 3'd1,
		CLS_MUL   = 3'd2,
		CLS_DIV   = 3'd3,
		CLS_ADD   = 3'd4,
		CLS_SUB   = 3'd5,
		CLS_OTHER = 3'd6
	} cls_t;

	typedef enum logic [1:0] {
		MOP_NONE = 2'd0,
		MOP_MUL  = 2'd1,
		MOP_DIV  = 2'd2
	} mulop_t;

	typedef struct packed {
		logic   digit;
		logic   close_run;
		logic   fold_start;
		mulop_t fold_kind;
		logic   mul_step;
		logic   div_step;
		logic   last_step;
		logic   close_term;
		logic   sub;
		logic   load_out;
		logic   out_err;
		logic   clr_all;
	} dp_cmd_t;

	typedef struct packed {
		logic opnd_zero;
	} dp_stat_t;

	function automatic cls_t classify(input logic [CHAR_W-1:0] c);
		cls_t r;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = CLS_DIGIT;
		end else if (c == CH_SPACE) begin
			r = CLS_SPACE;
		end else if (c == CH_STAR) begin
			r = CLS_MUL;
		end else if (c == CH_SLASH) begin
			r = CLS_DIV;
		end else if (c == CH_PLUS) begin
			r = CLS_ADD;
		end else if (c == CH_MINUS) begin
			r = CLS_SUB;
		end else begin
			r = CLS_OTHER;
		end
		return r;
	endfunction

endpackage

/* rtl/iae_expr_if.sv */
`timescale 1ns / 1ps

interface iae_expr_if;
	import iae_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              end_of_expr;

	modport source (output valid, output char_code, output end_of_expr, input ready);
	modport sink (input valid, input char_code, input end_of_expr, output ready);
endinterface

/* rtl/iae_result_if.sv */
`timescale 1ns / 1ps

interface iae_result_if;
	import iae_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      div_zero;

	modport source (output valid, output value, output div_zero, input ready);
	modport sink (input valid, input value, input div_zero, output ready);
endinterface

/* rtl/infix_arithmetic_evaluator_unit.sv */
// channel  | dir | payload                          | handshake
// ---------+-----+----------------------------------+-------------
// expr     | in  | char_code[7:0], end_of_expr      | valid/ready
// result   | out | value[63:0] signed, div_zero     | valid/ready
//
// A digit, space or other character that does not end the expression is handled as
// it is taken. An operator goes through a fold, then any multiply or divide steps of
// the pending term operation (both from one shared shift-and-add/subtract unit),
// then an apply. A final item adds one more fold and apply, then loads the result.
// Reset clears the evaluator state at once; no sweep follows.
// A stalled result holds in the output register while the next expression
// is taken; only loading a new result waits for it to drain.
`timescale 1ns / 1ps

module infix_arithmetic_evaluator_unit (
	input  logic         clk,
	input  logic         arst_n,
	iae_expr_if.sink     expr,
	iae_result_if.source result
);
	import iae_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	iae_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.expr_valid   (expr.valid),
		.expr_ready   (expr.ready),
		.char_code    (expr.char_code),
		.end_of_expr  (expr.end_of_expr),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	iae_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (expr.char_code),
		.cmd       (cmd),
		.stat      (stat),
		.value     (result.value),
		.div_zero  (result.div_zero)
	);

endmodule

/* rtl/iae_ctrl.sv */
`timescale 1ns / 1ps

module iae_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     expr_valid,
	output logic                     expr_ready,
	input  logic [iae_pkg::CHAR_W-1:0] char_code,
	input  logic                     end_of_expr,
	output logic                     result_valid,
	input  logic                     result_ready,
	input  iae_pkg::dp_stat_t        stat,
	output iae_pkg::dp_cmd_t         cmd
);
	import iae_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FOLD  = 6'b000010,
		S_MUL   = 6'b000100,
		S_DIV   = 6'b001000,
		S_APPLY = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		ACT_MULOP  = 2'd0,
		ACT_ADDSUB = 2'd1,
		ACT_END    = 2'd2
	} act_t;

	state_t           state_q, state_d;
	mulop_t           mulop_q, mulop_d;
	mulop_t           nmulop_q, nmulop_d;
	act_t             act_q, act_d;
	logic             sign_q, sign_d;
	logic             nsign_q, nsign_d;
	logic             err_q, err_d;
	logic             last_q, last_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic             accept;
	logic             plain;
	cls_t             cls;

	assign expr_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign accept       = expr_valid && expr_ready;
	assign cls          = classify(char_code);
	assign plain        = (cls == CLS_DIGIT) || (cls == CLS_SPACE) || (cls == CLS_OTHER);

	always_comb begin
		state_d     = state_q;
		mulop_d     = mulop_q;
		nmulop_d    = nmulop_q;
		act_d       = act_q;
		sign_d      = sign_q;
		nsign_d     = nsign_q;
		err_d       = err_q;
		last_d      = last_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && !result_ready;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					last_d = end_of_expr;
					if (err_q) begin
						if (end_of_expr) begin
							state_d = S_EMIT;
						end
					end else begin
						unique case (cls)
							CLS_DIGIT: cmd.digit = 1'b1;
							CLS_OTHER: cmd.close_run = 1'b1;
							CLS_MUL, CLS_DIV: begin
								act_d    = ACT_MULOP;
								nmulop_d = (cls == CLS_MUL) ? MOP_MUL : MOP_DIV;
								state_d  = S_FOLD;
							end
							CLS_ADD, CLS_SUB: begin
								act_d   = ACT_ADDSUB;
								nsign_d = (cls == CLS_SUB);
								state_d = S_FOLD;
							end
							default: ;
						endcase
						if (plain && end_of_expr) begin
							act_d   = ACT_END;
							state_d = S_FOLD;
						end
					end
				end
			end
			S_FOLD: begin
				cmd.fold_start = 1'b1;
				cmd.fold_kind  = mulop_q;
				unique case (mulop_q)
					MOP_MUL: begin
						cnt_d   = CNT_W'(NUMBER_BITS - 1);
						state_d = S_MUL;
					end
					MOP_DIV: begin
						if (stat.opnd_zero) begin
							err_d   = 1'b1;
							state_d = S_APPLY;
						end else begin
							cnt_d   = CNT_W'(TERM_BITS - 1);
							state_d = S_DIV;
						end
					end
					default: state_d = S_APPLY;
				endcase
			end
			S_MUL: begin
				cmd.mul_step  = 1'b1;
				cmd.last_step = (cnt_q == '0);
				cnt_d         = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					state_d = S_APPLY;
				end
			end
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.last_step = (cnt_q == '0);
				cnt_d         = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.sub = sign_q;
				unique case (act_q)
					ACT_MULOP: mulop_d = nmulop_q;
					ACT_ADDSUB: begin
						cmd.close_term = !err_q;
						mulop_d        = MOP_NONE;
						sign_d         = nsign_q;
					end
					default: cmd.close_term = !err_q;
				endcase
				if (act_q == ACT_END) begin
					state_d = S_EMIT;
				end else if (last_q) begin
					if (err_q) begin
						state_d = S_EMIT;
					end else begin
						act_d   = ACT_END;
						state_d = S_FOLD;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					cmd.out_err  = err_q;
					cmd.clr_all  = 1'b1;
					mulop_d      = MOP_NONE;
					sign_d       = 1'b0;
					err_d        = 1'b0;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mulop_q     <= MOP_NONE;
			nmulop_q    <= MOP_NONE;
			act_q       <= ACT_MULOP;
			sign_q      <= 1'b0;
			nsign_q     <= 1'b0;
			err_q       <= 1'b0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mulop_q     <= mulop_d;
			nmulop_q    <= nmulop_d;
			act_q       <= act_d;
			sign_q      <= sign_d;
			nsign_q     <= nsign_d;
			err_q       <= err_d;
			last_q      <= last_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

/* rtl/iae_dpath.sv */
`timescale 1ns / 1ps

module iae_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [iae_pkg::CHAR_W-1:0]        char_code,
	input  iae_pkg::dp_cmd_t                  cmd,
	output iae_pkg::dp_stat_t                 stat,
	output logic signed [iae_pkg::VALUE_W-1:0] value,
	output logic                              div_zero
);
	import iae_pkg::*;

	localparam int NB = NUMBER_BITS;

	logic [NB-1:0]      digit_q;
	logic               nopen_q;
	logic [VALUE_W-1:0] term_q;
	logic [VALUE_W-1:0] sum_q;
	logic [VALUE_W-1:0] acc_q;
	logic               sat_q;
	logic [NB-1:0]      rem_q;
	logic [NB-1:0]      opnd_q;
	logic [VALUE_W-1:0] value_q;
	logic               div_zero_q;

	logic [NB-1:0]      base;
	logic [NB+3:0]      dig_sum;
	logic [NB-1:0]      digit_n;
	logic [VALUE_W:0]   prod;
	logic               sat_n;
	logic [NB:0]        r2;
	logic [NB:0]        diff;
	logic               ge;
	logic [NB-1:0]      rem_n;
	logic [VALUE_W-1:0] quo_n;
	logic [VALUE_W:0]   s65;
	logic [VALUE_W:0]   t65;
	logic [VALUE_W:0]   r65;
	logic [VALUE_W-1:0] sum_n;
	logic [VALUE_W-1:0] x;

	assign base    = nopen_q ? digit_q : '0;
	assign dig_sum = ({4'b0, base} << 3) + ({4'b0, base} << 1) + (NB+4)'(char_code[3:0]);
	assign digit_n = (dig_sum[NB+3:NB] != '0) ? '1 : dig_sum[NB-1:0];

	assign prod  = {acc_q, 1'b0} + (opnd_q[NB-1] ? {1'b0, term_q} : '0);
	assign sat_n = sat_q | prod[VALUE_W] | prod[VALUE_W-1];

	assign r2    = {rem_q, acc_q[TERM_BITS-1]};
	assign diff  = r2 - {1'b0, opnd_q};
	assign ge    = (r2 >= {1'b0, opnd_q});
	assign rem_n = ge ? diff[NB-1:0] : r2[NB-1:0];
	assign quo_n = {acc_q[VALUE_W-2:0], ge};

	assign s65   = {sum_q[VALUE_W-1], sum_q};
	assign t65   = {1'b0, term_q};
	assign r65   = cmd.sub ? (s65 - t65) : (s65 + t65);
	assign sum_n = (r65[VALUE_W] != r65[VALUE_W-1]) ? (r65[VALUE_W] ? SMIN : SMAX)
		: r65[VALUE_W-1:0];

	assign x = VALUE_W'(digit_q) << FRAC_BITS;

	assign stat.opnd_zero = (digit_q == '0);
	assign value          = value_q;
	assign div_zero       = div_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			nopen_q <= 1'b0;
			term_q  <= '0;
			sum_q   <= '0;
		end else if (cmd.clr_all) begin
			digit_q <= '0;
			nopen_q <= 1'b0;
			term_q  <= '0;
			sum_q   <= '0;
		end else begin
			if (cmd.digit) begin
				digit_q <= digit_n;
				nopen_q <= 1'b1;
			end
			if (cmd.close_run) begin
				nopen_q <= 1'b0;
			end
			if (cmd.fold_start) begin
				digit_q <= '0;
				nopen_q <= 1'b0;
				if (cmd.fold_kind == MOP_NONE) begin
					term_q <= x;
				end
			end
			if (cmd.mul_step && cmd.last_step) begin
				term_q <= sat_n ? SMAX : prod[VALUE_W-1:0];
			end
			if (cmd.div_step && cmd.last_step) begin
				term_q <= {1'b0, quo_n[TERM_BITS-1:0]};
			end
			if (cmd.close_term) begin
				sum_q  <= sum_n;
				term_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fold_start) begin
			opnd_q <= digit_q;
			rem_q  <= '0;
			sat_q  <= 1'b0;
			acc_q  <= (cmd.fold_kind == MOP_DIV) ? term_q : '0;
		end
		if (cmd.mul_step) begin
			acc_q  <= prod[VALUE_W-1:0];
			sat_q  <= sat_n;
			opnd_q <= opnd_q << 1;
		end
		if (cmd.div_step) begin
			acc_q <= quo_n;
			rem_q <= rem_n;
		end
		if (cmd.load_out) begin
			value_q    <= cmd.out_err ? '0 : sum_q;
			div_zero_q <= cmd.out_err;
		end
	end

endmodule

/* rtl/iae_checker.sv */
`timescale 1ns / 1ps

module iae_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              expr_valid,
	input logic                              expr_ready,
	input logic                              expr_end,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic signed [iae_pkg::VALUE_W-1:0] result_value,
	input logic                              result_div_zero
);
	import iae_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_value) && $stable(result_div_zero))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_div_zero |-> result_value == '0)
		else $error("division error with nonzero value");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		expr_valid && expr_ready && !expr_end && !result_valid |=> !result_valid)
		else $error("result without end item");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		expr_valid && expr_ready && expr_end |=> !expr_ready)
		else $error("item taken while closing expression");

endmodule

bind infix_arithmetic_evaluator_unit iae_checker u_iae_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.expr_valid      (expr.valid),
	.expr_ready      (expr.ready),
	.expr_end        (expr.end_of_expr),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_value    (result.value),
	.result_div_zero (result.div_zero)
);

/* tb/sv/tb_infix_arithmetic_evaluator_unit.sv */
`timescale 1ns / 1ps

module tb_infix_arithmetic_evaluator_unit;
	import iae_pkg::*;

	localparam int RANDOM_ITEMS = 550;
	localparam int DIRECTED_EXPRS = 5;
	localparam logic [VALUE_W-1:0] NUM_MAX = (64'd1 << NUMBER_BITS) - 64'd1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      div_zero;
	} result_t;

	typedef struct {
		string   text;
		bit      typed;
		result_t res;
	} expr_case_t;

	logic clk = 1'b0;
	logic arst_n;

	iae_expr_if   expr_ch();
	iae_result_if result_ch();

	infix_arithmetic_evaluator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.expr   (expr_ch),
		.result (result_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// evaluator state
	logic [NUMBER_BITS-1:0]    num_acc;
	logic                      num_open;
	logic [VALUE_W-1:0]        term_acc;
	mulop_t                    term_op;
	logic signed [VALUE_W-1:0] sum_acc;
	logic                      sub_next;
	logic                      dz_seen;

	result_t     pending_results[$];
	logic [7:0]  expr_text[$];
	expr_case_t  directed_cases[DIRECTED_EXPRS];
	int          mismatches = 0;
	int          chars_counted = 0;
	int          results_seen = 0;
	int          dz_results = 0;
	int          saturated = 0;
	bit          calm = 1'b0;
	bit          hold_request = 1'b0;

	task automatic clear_evaluator();
		num_acc = '0;
		num_open = 1'b0;
		term_acc = '0;
		term_op = MOP_NONE;
		sum_acc = '0;
		sub_next = 1'b0;
		dz_seen = 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] fx_product(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		logic [2*VALUE_W-1:0] p;
		p = {{VALUE_W{1'b0}}, a} * {{VALUE_W{1'b0}}, b};
		if (p[2*VALUE_W-1:VALUE_W+FRAC_BITS] != '0 || p[VALUE_W+FRAC_BITS-1]) begin
			return SMAX;
		end
		return p[VALUE_W+FRAC_BITS-1:FRAC_BITS];
	endfunction

	function automatic logic [VALUE_W-1:0] fx_quotient(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		logic [2*VALUE_W-1:0] num;
		logic [2*VALUE_W-1:0] q;
		if ((a >> (VALUE_W - FRAC_BITS)) >= b) begin
			return SMAX;
		end
		num = {{(VALUE_W-FRAC_BITS){1'b0}}, a, {FRAC_BITS{1'b0}}};
		q = num / {{VALUE_W{1'b0}}, b};
		if (q[VALUE_W-1]) begin
			return SMAX;
		end
		return q[VALUE_W-1:0];
	endfunction

	task automatic fold_number();
		logic [VALUE_W-1:0] x;
		x = {{(VALUE_W-NUMBER_BITS-FRAC_BITS){1'b0}}, num_acc, {FRAC_BITS{1'b0}}};
		num_acc = '0;
		num_open = 1'b0;
		case (term_op)
			MOP_MUL: begin
				term_acc = fx_product(term_acc, x);
			end
			MOP_DIV: begin
				if (x == '0) begin
					dz_seen = 1'b1;
				end else begin
					term_acc = fx_quotient(term_acc, x);
				end
			end
			default: begin
				term_acc = x;
			end
		endcase
	endtask

	task automatic close_term();
		logic [VALUE_W+1:0] wide;
		wide = {{2{sum_acc[VALUE_W-1]}}, sum_acc};
		if (sub_next) begin
			wide = wide - {2'b00, term_acc};
		end else begin
			wide = wide + {2'b00, term_acc};
		end
		if (wide[VALUE_W+1:VALUE_W-1] == 3'b000 || wide[VALUE_W+1:VALUE_W-1] == 3'b111) begin
			sum_acc = wide[VALUE_W-1:0];
		end else if (wide[VALUE_W+1]) begin
			sum_acc = SMIN;
		end else begin
			sum_acc = SMAX;
		end
		term_acc = '0;
	endtask

	task automatic evaluate_char(input logic [CHAR_W-1:0] c, input logic last,
			output bit produced, output result_t res);
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] grown;
		res = '0;
		if (!dz_seen) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				base = '0;
				if (num_open) begin
					base[NUMBER_BITS-1:0] = num_acc;
				end
				grown = base * 64'd10 + {{(VALUE_W-CHAR_W){1'b0}}, c - CH_ZERO};
				num_acc = (grown > NUM_MAX) ? NUM_MAX[NUMBER_BITS-1:0] : grown[NUMBER_BITS-1:0];
				num_open = 1'b1;
			end else if (c == CH_SPACE) begin
			end else if (c == CH_STAR || c == CH_SLASH) begin
				fold_number();
				if (c == CH_STAR) begin
					term_op = MOP_MUL;
				end else begin
					term_op = MOP_DIV;
				end
			end else if (c == CH_PLUS || c == CH_MINUS) begin
				fold_number();
				if (!dz_seen) begin
					close_term();
				end
				term_op = MOP_NONE;
				sub_next = (c == CH_MINUS);
			end else begin
				num_open = 1'b0;
			end
		end
		produced = last;
		if (last) begin
			if (!dz_seen) begin
				fold_number();
				if (!dz_seen) begin
					close_term();
				end
			end
			res.div_zero = dz_seen;
			res.value = dz_seen ? '0 : sum_acc;
			clear_evaluator();
		end
	endtask

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			flag_mismatch($sformatf("unexpected result value=%0d div_zero=%0b",
				got.value, got.div_zero));
			return;
		end
		want = pending_results.pop_front();
		results_seen++;
		if (got.value !== want.value) begin
			flag_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
		end
		if (got.div_zero !== want.div_zero) begin
			flag_mismatch($sformatf("div_zero %0b, want %0b", got.div_zero, want.div_zero));
		end
		if (want.div_zero) begin
			dz_results++;
		end
		if (want.value == SMAX || want.value == SMIN) begin
			saturated++;
		end
	endtask

	function automatic logic [CHAR_W-1:0] random_other();
		logic [CHAR_W-1:0] c;
		do begin
			c = CHAR_W'($urandom_range(0, 255));
		end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_PLUS ||
			c == CH_MINUS || c == CH_STAR || c == CH_SLASH);
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] random_operator();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	task automatic build_expression();
		int kind;
		int terms;
		int pick;
		int ndig;
		kind = $urandom_range(0, 99);
		expr_text.delete();
		if (kind < 10) begin
			repeat ($urandom_range(1, 6)) expr_text.push_back(CHAR_W'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 5) == 0) begin
			expr_text.push_back(random_operator());
		end
		terms = $urandom_range(1, 5);
		for (int t = 0; t < terms; t++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				ndig = 0;
			end else if (pick == 1) begin
				ndig = 0;
				expr_text.push_back(CH_ZERO);
			end else if (pick < 4) begin
				ndig = $urandom_range(10, 11);
			end else if (pick < 8) begin
				ndig = $urandom_range(3, 6);
			end else begin
				ndig = $urandom_range(1, 2);
			end
			for (int d = 0; d < ndig; d++) begin
				expr_text.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
				if ($urandom_range(0, 9) == 0) begin
					expr_text.push_back(CH_SPACE);
				end
				if ($urandom_range(0, 39) == 0) begin
					expr_text.push_back(random_other());
				end
			end
			if (t < terms - 1) begin
				expr_text.push_back(random_operator());
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			expr_text.push_back(random_operator());
		end
		if (kind < 20) begin
			expr_text.insert($urandom_range(0, expr_text.size()), random_other());
		end
		if (expr_text.size() == 0) begin
			expr_text.push_back(CH_SPACE);
		end
	endtask

	task automatic offer_item(input logic [CHAR_W-1:0] c, input logic last, input bit typed,
			input result_t typed_res);
		bit ignored;
		bit produced;
		result_t predicted;
		while (!calm && $urandom_range(0, 99) < 12) begin
			expr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		expr_ch.valid <= 1'b1;
		expr_ch.char_code <= c;
		expr_ch.end_of_expr <= last;
		@(posedge clk);
		while (!expr_ch.ready) @(posedge clk);
		ignored = dz_seen && !last;
		evaluate_char(c, last, produced, predicted);
		if (!ignored) begin
			chars_counted++;
		end
		if (produced) begin
			pending_results.push_back(typed ? typed_res : predicted);
		end
	endtask

	// result side: check, then pick ready for the next cycle
	initial begin
		int hold_left;
		hold_left = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				check_result('{result_ch.value, result_ch.div_zero});
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
			end
		end
	end

	initial begin
		bit drained;
		bit held;
		int len;
		drained = 1'b0;
		held = 1'b0;
		arst_n = 1'b0;
		expr_ch.valid = 1'b0;
		expr_ch.char_code = '0;
		expr_ch.end_of_expr = 1'b0;
		clear_evaluator();

		directed_cases[0] = '{"\377", 1'b1, '{64'sd0, 1'b0}};
		directed_cases[1] = '{"-7", 1'b1, '{-64'sd458752, 1'b0}};
		directed_cases[2] = '{"8/0+", 1'b1, '{64'sd0, 1'b1}};
		directed_cases[3] = '{"4 2*3/2-", 1'b0, '0};
		directed_cases[4] = '{"9999999999", 1'b1, '{64'sh0000_7FFF_FFFF_0000, 1'b0}};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_EXPRS; i++) begin
			len = directed_cases[i].text.len();
			for (int j = 0; j < len; j++) begin
				offer_item(directed_cases[i].text[j], j == len - 1, directed_cases[i].typed,
					directed_cases[i].res);
			end
		end

		chars_counted = 0;
		while (chars_counted < RANDOM_ITEMS) begin
			if (!drained && chars_counted >= 150) begin
				drained = 1'b1;
				expr_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			if (!held && chars_counted >= 300) begin
				held = 1'b1;
				hold_request = 1'b1;
			end
			calm = (chars_counted >= 400 && chars_counted < 480);
			build_expression();
			foreach (expr_text[j]) begin
				offer_item(expr_text[j], j == expr_text.size() - 1, 1'b0, '0);
			end
		end
		calm = 1'b0;

		expr_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Checked %0d expression results: %0d divide-by-zero, %0d saturated.",
			results_seen, dz_results, saturated);
		$display("Stimulus: %0d directed expressions plus %0d random characters.",
			DIRECTED_EXPRS, chars_counted);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/iae_pkg.sv
rtl/iae_expr_if.sv
rtl/iae_result_if.sv
rtl/iae_ctrl.sv
rtl/iae_dpath.sv
rtl/infix_arithmetic_evaluator_unit.sv
rtl/iae_checker.sv
tb/sv/tb_infix_arithmetic_evaluator_unit.sv
